/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* design/mcr_pkg.sv */
`timescale 1ns / 1ps

package mcr_pkg;

   localparam int PIX_W     = 8;
   localparam int COORD_W   = 8;
   localparam int DIM_W     = 9;
   localparam int THR_W     = 20;
   localparam int CSR_IDX_W = 2;
   localparam int MAX_WIDTH = 256;
   localparam int WIN       = 3;
   localparam int HALF      = WIN / 2;
   localparam int SPAN      = WIN + 2;
   localparam int LAG       = WIN - HALF;
   localparam int SLOT_W    = $clog2(SPAN);
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int NUM_DIR   = 4;
   localparam int SQ_W      = 2 * PIX_W;
   localparam int PART_W    = SQ_W + 2;
   localparam int RESP_W    = 20;

   localparam logic [DIM_W-1:0]   DIM_MIN         = DIM_W'(8);
   localparam logic [DIM_W-1:0]   DIM_MAX         = DIM_W'(256);
   localparam logic [DIM_W-1:0]   WIDTH_RESET     = DIM_W'(256);
   localparam logic [DIM_W-1:0]   HEIGHT_RESET    = DIM_W'(256);
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(42000);

   // one-pixel shifts as (row, column) offsets: left, up, down, right
   localparam int SHIFT_DY [NUM_DIR] = '{0, -1, 1, 0};
   localparam int SHIFT_DX [NUM_DIR] = '{-1, 0, 0, 1};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH      = 2'd0,
      CSR_IMAGE_HEIGHT     = 2'd1,
      CSR_CORNER_THRESHOLD = 2'd2
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [SPAN-1:0][PIX_W-1:0] column_type;
   // indexed [row][column], oldest row and column at index 0
   typedef logic [SPAN-1:0][SPAN-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic               emit;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
   } tag_type;

   typedef struct packed {
      logic               emit;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [RESP_W-1:0]  response;
   } res_type;

   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [RESP_W-1:0]  response;
      logic               is_corner;
   } out_type;

   function automatic logic [SQ_W-1:0] sq_abs_diff(input pixel_type a, input pixel_type b);
      logic [PIX_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return {{PIX_W{1'b0}}, d} * {{PIX_W{1'b0}}, d};
   endfunction

endpackage

/* design/mcr_ram.sv */
`timescale 1ns / 1ps

module mcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mcr_column_cell.sv */
`timescale 1ns / 1ps

// one window column; hands its pixels to the next older column on each shift
module mcr_column_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  mcr_pkg::column_type col_in,
   output mcr_pkg::column_type col_out
);

   mcr_pkg::column_type column_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         column_ff <= col_in;
      end
   end

   assign col_out = column_ff;

endmodule

/* design/mcr_ssd.sv */
`timescale 1ns / 1ps

// squared differences, partial sums, direction sums, minimum
module mcr_ssd (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  mcr_pkg::tag_type    tag_in,
   input  mcr_pkg::window_type window,
   output mcr_pkg::res_type    res
);

   localparam int NSQ = mcr_pkg::WIN * mcr_pkg::WIN;

   mcr_pkg::tag_type tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   mcr_pkg::res_type res6_ff;

   logic [mcr_pkg::NUM_DIR-1:0][NSQ-1:0][mcr_pkg::SQ_W-1:0]              sq3_in, sq3_ff;
   logic [mcr_pkg::NUM_DIR-1:0][mcr_pkg::WIN-1:0][mcr_pkg::PART_W-1:0]   part4_in, part4_ff;
   logic [mcr_pkg::NUM_DIR-1:0][mcr_pkg::RESP_W-1:0]                     sum5_in, sum5_ff;
   logic [mcr_pkg::RESP_W-1:0] min01, min23, min6_in;

   // squared differences against each shifted window
   for (genvar k = 0; k < mcr_pkg::NUM_DIR; k++) begin : g_dir
      for (genvar i = 0; i < mcr_pkg::WIN; i++) begin : g_row
         for (genvar j = 0; j < mcr_pkg::WIN; j++) begin : g_col
            localparam int R0 = 1 + i;
            localparam int C0 = 1 + j;
            localparam int R1 = 1 + i + mcr_pkg::SHIFT_DY[k];
            localparam int C1 = 1 + j + mcr_pkg::SHIFT_DX[k];
            assign sq3_in[k][i*mcr_pkg::WIN+j] =
               mcr_pkg::sq_abs_diff(window[R0][C0], window[R1][C1]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < mcr_pkg::NUM_DIR; k++) begin
         for (int g = 0; g < mcr_pkg::WIN; g++) begin
            part4_in[k][g] = {2'b00, sq3_ff[k][g*mcr_pkg::WIN]}
                           + {2'b00, sq3_ff[k][g*mcr_pkg::WIN+1]}
                           + {2'b00, sq3_ff[k][g*mcr_pkg::WIN+2]};
         end
         sum5_in[k] = {2'b00, part4_ff[k][0]} + {2'b00, part4_ff[k][1]}
                    + {2'b00, part4_ff[k][2]};
      end
      min01   = (sum5_ff[1] < sum5_ff[0]) ? sum5_ff[1] : sum5_ff[0];
      min23   = (sum5_ff[3] < sum5_ff[2]) ? sum5_ff[3] : sum5_ff[2];
      min6_in = (min23 < min01) ? min23 : min01;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff.emit <= 1'b0;
         tag3_ff.emit <= 1'b0;
         tag4_ff.emit <= 1'b0;
         tag5_ff.emit <= 1'b0;
         res6_ff.emit <= 1'b0;
      end else if (advance) begin
         tag2_ff <= tag_in;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
         res6_ff <= '{emit: tag5_ff.emit, cx: tag5_ff.cx, cy: tag5_ff.cy,
                      response: min6_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq3_ff   <= sq3_in;
         part4_ff <= part4_in;
         sum5_ff  <= sum5_in;
      end
   end

   assign res = res6_ff;

endmodule

/* design/moravec_corner_response.sv */
`timescale 1ns / 1ps

// Moravec corner response over a 3x3 window. Grey pixels enter one per clock in
// raster order; for every interior centre (two pixels clear of each edge) one
// transaction leaves with the centre coordinates, the smallest of the four
// one-pixel-shift sums of squared differences, and a corner flag set when that
// sum exceeds corner_threshold. Sustained rate is one pixel per clock. Once the
// pixel completing a centre's 5x5 neighbourhood is accepted, its result passes
// the bank read, window cells, SSD registers and output buffer to rsp_valid.
// The block holds off new pixels only when both slots of its two-deep output
// buffer are full and another result reaches the end of the pipeline. The four
// previous rows live in five 256x8 line-store banks (one write and one read port
// each, no clearing after reset); a chain of five column cells forms the window.
// Image width and height are clamped to 8..256 and should be written only while
// the block is idle.
module moravec_corner_response (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mcr_pkg::PIX_W-1:0]       req_pixel,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mcr_pkg::COORD_W-1:0]     rsp_center_x,
   output logic [mcr_pkg::COORD_W-1:0]     rsp_center_y,
   output logic [mcr_pkg::RESP_W-1:0]      rsp_response,
   output logic                            rsp_is_corner,
   // configuration writes
   input  logic                            csr_write_en,
   input  logic [mcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mcr_pkg::THR_W-1:0]       csr_data
);

   // configuration registers
   logic [mcr_pkg::DIM_W-1:0] image_width_ff, image_height_ff;
   logic [mcr_pkg::THR_W-1:0] threshold_ff;
   logic [mcr_pkg::DIM_W-1:0] width_eff, height_eff;

   // raster position of the next pixel, plus its line-store bank
   logic [mcr_pkg::COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [mcr_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic row_end, frame_end;

   // handshake and global pipeline enable
   logic accept, advance, push, pop;

   // first stage: line-store read in flight
   logic                       s1_valid_ff;
   mcr_pkg::tag_type           s1_tag_ff;
   mcr_pkg::pixel_type         s1_pixel_ff;
   logic [mcr_pkg::SLOT_W-1:0] s1_slot_ff;

   mcr_pkg::pixel_type  bank_rd [mcr_pkg::SPAN];
   mcr_pkg::column_type new_col;
   mcr_pkg::column_type cell_col [mcr_pkg::SPAN];
   mcr_pkg::window_type window;
   mcr_pkg::tag_type    tag_to_ssd;
   mcr_pkg::res_type    res;

   // two-deep output buffer
   logic             head_valid_ff, head_valid_in, skid_valid_ff, skid_valid_in;
   mcr_pkg::out_type head_ff, head_in, skid_ff, skid_in, new_out;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= mcr_pkg::WIDTH_RESET;
         image_height_ff <= mcr_pkg::HEIGHT_RESET;
         threshold_ff    <= mcr_pkg::THRESHOLD_RESET;
      end else if (csr_write_en) begin
         unique case (mcr_pkg::csr_index_type'(csr_index))
            mcr_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[mcr_pkg::DIM_W-1:0];
            end
            mcr_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_data[mcr_pkg::DIM_W-1:0];
            end
            mcr_pkg::CSR_CORNER_THRESHOLD: begin
               threshold_ff <= csr_data;
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // dimensions saturated into the supported range
   always_comb begin
      if (image_width_ff < mcr_pkg::DIM_MIN) begin
         width_eff = mcr_pkg::DIM_MIN;
      end else if (image_width_ff > mcr_pkg::DIM_MAX) begin
         width_eff = mcr_pkg::DIM_MAX;
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff < mcr_pkg::DIM_MIN) begin
         height_eff = mcr_pkg::DIM_MIN;
      end else if (image_height_ff > mcr_pkg::DIM_MAX) begin
         height_eff = mcr_pkg::DIM_MAX;
      end else begin
         height_eff = image_height_ff;
      end
   end

   // -------------------------------------------------------------- handshake
   // whole pipeline moves together; it stops only when a result is ready to
   // leave and both output slots are taken
   assign advance   = ~(res.emit & skid_valid_ff);
   assign req_stall = ~advance;
   assign accept    = req_valid & advance;
   assign pop       = head_valid_ff & ~rsp_stall;
   assign push      = advance & res.emit;

   // ---------------------------------------------------------- raster counters
   always_comb begin
      row_end   = ({1'b0, col_ff} + mcr_pkg::DIM_W'(1)) >= width_eff;
      frame_end = ({1'b0, row_ff} + mcr_pkg::DIM_W'(1)) >= height_eff;
      col_in    = col_ff;
      row_in    = row_ff;
      slot_in   = slot_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            if (frame_end) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + mcr_pkg::COORD_W'(1);
               slot_in = (slot_ff == mcr_pkg::SLOT_W'(mcr_pkg::SPAN - 1)) ?
                         '0 : slot_ff + mcr_pkg::SLOT_W'(1);
            end
         end else begin
            col_in = col_ff + mcr_pkg::COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // ------------------------------------------------------------ line store
   // bank b keeps the rows whose number is b modulo five; the incoming pixel
   // goes to its own row's bank while the same column is read from all banks
   for (genvar b = 0; b < mcr_pkg::SPAN; b++) begin : g_bank
      mcr_ram #(
         .WIDTH (mcr_pkg::PIX_W),
         .DEPTH (mcr_pkg::MAX_WIDTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (accept && (slot_ff == mcr_pkg::SLOT_W'(b))),
         .wr_addr (col_ff),
         .wr_data (req_pixel),
         .rd_en   (accept),
         .rd_addr (col_ff),
         .rd_data (bank_rd[b])
      );
   end

   // first stage keeps the transaction's position while the banks are read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff.emit <= (col_ff >= mcr_pkg::COORD_W'(mcr_pkg::SPAN - 1)) &&
                           (row_ff >= mcr_pkg::COORD_W'(mcr_pkg::SPAN - 1));
         s1_tag_ff.cx   <= col_ff;
         s1_tag_ff.cy   <= row_ff;
         s1_pixel_ff    <= req_pixel;
         s1_slot_ff     <= slot_ff;
      end
   end

   // new column, oldest row first: banks after the current one in rotation,
   // then the pixel itself
   always_comb begin
      logic [mcr_pkg::SLOT_W:0] slot_sum;
      for (int a = 0; a < mcr_pkg::SPAN - 1; a++) begin
         slot_sum = {1'b0, s1_slot_ff} + (mcr_pkg::SLOT_W + 1)'(a + 1);
         if (slot_sum >= (mcr_pkg::SLOT_W + 1)'(mcr_pkg::SPAN)) begin
            slot_sum = slot_sum - (mcr_pkg::SLOT_W + 1)'(mcr_pkg::SPAN);
         end
         new_col[a] = bank_rd[slot_sum[mcr_pkg::SLOT_W-1:0]];
      end
      new_col[mcr_pkg::SPAN-1] = s1_pixel_ff;
   end

   // ------------------------------------------------------ window cell chain
   // cell 0 holds the newest column, the last cell the oldest
   for (genvar c = 0; c < mcr_pkg::SPAN; c++) begin : g_cell
      if (c == 0) begin : g_head
         mcr_column_cell u_cell (
            .clock    (clock),
            .shift_en (advance & s1_valid_ff),
            .col_in   (new_col),
            .col_out  (cell_col[c])
         );
      end else begin : g_tail
         mcr_column_cell u_cell (
            .clock    (clock),
            .shift_en (advance & s1_valid_ff),
            .col_in   (cell_col[c-1]),
            .col_out  (cell_col[c])
         );
      end
   end

   for (genvar a = 0; a < mcr_pkg::SPAN; a++) begin : g_win_row
      for (genvar b = 0; b < mcr_pkg::SPAN; b++) begin : g_win_col
         assign window[a][b] = cell_col[mcr_pkg::SPAN-1-b][a];
      end
   end

   // only a live transaction with a full neighbourhood produces a result
   always_comb begin
      tag_to_ssd      = s1_tag_ff;
      tag_to_ssd.emit = s1_valid_ff & s1_tag_ff.emit;
   end

   // --------------------------------------------------------- response maths
   mcr_ssd u_ssd (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tag_in  (tag_to_ssd),
      .window  (window),
      .res     (res)
   );

   // ---------------------------------------------------------- output buffer
   always_comb begin
      new_out.center_x  = res.cx - mcr_pkg::COORD_W'(mcr_pkg::LAG);
      new_out.center_y  = res.cy - mcr_pkg::COORD_W'(mcr_pkg::LAG);
      new_out.response  = res.response;
      new_out.is_corner = res.response > threshold_ff;

      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (head_valid_in) begin
            skid_in       = new_out;
            skid_valid_in = 1'b1;
         end else begin
            head_in       = new_out;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = head_valid_ff;
   assign rsp_center_x  = head_ff.center_x;
   assign rsp_center_y  = head_ff.center_y;
   assign rsp_response  = head_ff.response;
   assign rsp_is_corner = head_ff.is_corner;

endmodule

/* design/mcr_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mcr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [mcr_pkg::COORD_W-1:0] rsp_center_x,
   input logic [mcr_pkg::COORD_W-1:0] rsp_center_y,
   input logic [mcr_pkg::RESP_W-1:0]  rsp_response,
   input logic                        rsp_is_corner
);

   `ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(rsp_stable_a, clock, reset, rsp_valid && rsp_stall, $stable(rsp_response) && $stable(rsp_center_x) && $stable(rsp_center_y) && $stable(rsp_is_corner))
   `ASSERT_IMPLY(resp_range_a, clock, reset, rsp_valid, rsp_response <= 20'd585225)
   `ASSERT_IMPLY(center_range_a, clock, reset, rsp_valid, rsp_center_x >= 8'd2 && rsp_center_y >= 8'd2)
   `ASSERT_IMPLY(flat_not_corner_a, clock, reset, rsp_valid && rsp_response == '0, !rsp_is_corner)

endmodule

bind moravec_corner_response mcr_checker u_mcr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_center_x  (rsp_center_x),
   .rsp_center_y  (rsp_center_y),
   .rsp_response  (rsp_response),
   .rsp_is_corner (rsp_is_corner)
);

/* tb/sv/tb_moravec_corner_response.sv */
`timescale 1ns / 1ps

module tb_moravec_corner_response;

   localparam int          LINE_ROWS     = 5;     // rows held for a 3x3 window and its shifts
   localparam int          LINE_LEN      = 256;
   localparam int unsigned RESP_CAP      = 20'hFFFFF;
   localparam int unsigned ITEM_BUDGET   = 1150;  // target for pixels sent over the whole run
   localparam int unsigned WIDE_AFTER    = 300;   // pixels sent before the full-width rows
   localparam int unsigned WIDE_PIXELS   = LINE_LEN + LINE_LEN / 2;
   localparam int unsigned SETTLE_CYCLES = 12;    // extra wait once every owed result is back
   localparam int unsigned TAIL_CYCLES   = 20;
   localparam int unsigned IDLE_LIMIT    = 2000;

   // one-pixel shifts as (row, column): up, left, right, down
   localparam int SHIFT_ROW [4] = '{-1, 0, 0, 1};
   localparam int SHIFT_COL [4] = '{0, -1, 1, 0};

   typedef enum int unsigned {
      PAT_NOISE,
      PAT_ALTERNATE,
      PAT_FLAT,
      PAT_SPIKES,
      PAT_EXTREMES,
      PAT_RAMP
   } pattern_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   mcr_pkg::pixel_type            req_pixel = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mcr_pkg::COORD_W-1:0]   rsp_center_x;
   logic [mcr_pkg::COORD_W-1:0]   rsp_center_y;
   logic [mcr_pkg::RESP_W-1:0]    rsp_response;
   logic                          rsp_is_corner;
   logic                          csr_write_en = 1'b0;
   mcr_pkg::csr_index_type        csr_index = mcr_pkg::CSR_IMAGE_WIDTH;
   logic [mcr_pkg::THR_W-1:0]     csr_data = '0;

   // pixels waiting to be sent, and results the block still owes us
   mcr_pkg::pixel_type            pixel_q [$];
   mcr_pkg::out_type              expected_q [$];

   // model of the block: register copies (reset values), raster position, line rows
   logic [mcr_pkg::DIM_W-1:0]     width_cfg = 9'd256;
   logic [mcr_pkg::DIM_W-1:0]     height_cfg = 9'd256;
   logic [mcr_pkg::THR_W-1:0]     thresh_cfg = 20'd42000;
   int unsigned                   col_pos = 0;
   int unsigned                   row_pos = 0;
   mcr_pkg::pixel_type            line_rows [LINE_ROWS][LINE_LEN];

   int unsigned                   sent_items = 0;
   int unsigned                   mismatch_count = 0;
   int unsigned                   idle_cycles = 0;
   int unsigned                   gap_left = 0;
   int unsigned                   send_burst = 0;
   int unsigned                   stall_left = 0;
   int unsigned                   stall_burst = 0;

   moravec_corner_response u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_center_x  (rsp_center_x),
      .rsp_center_y  (rsp_center_y),
      .rsp_response  (rsp_response),
      .rsp_is_corner (rsp_is_corner),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // corner response prediction
   // ------------------------------------------------------------------

   // dimensions are saturated into 8..256 when used
   function automatic int unsigned clamp_dim(input logic [mcr_pkg::DIM_W-1:0] raw);
      if (raw < 9'd8) return 8;
      if (raw > 9'd256) return 256;
      return raw;
   endfunction

   // one accepted pixel: store it, score the window that it completes, step the raster
   function automatic void predict_pixel(input mcr_pkg::pixel_type px);
      int unsigned        w, h, cx, cy, best, sum, slot;
      int                 a, b, k, i, j, d;
      mcr_pkg::pixel_type nbhd [LINE_ROWS][LINE_ROWS];
      mcr_pkg::out_type   want;
      w  = clamp_dim(width_cfg);
      h  = clamp_dim(height_cfg);
      cx = col_pos % LINE_LEN;
      cy = row_pos;
      line_rows[cy % LINE_ROWS][cx] = px;
      // the 5x5 neighbourhood ending at the newest pixel is complete
      if (cx >= LINE_ROWS - 1 && cy >= LINE_ROWS - 1) begin
         for (a = 0; a < LINE_ROWS; a++) begin
            slot = (cy - (LINE_ROWS - 1) + a) % LINE_ROWS;
            for (b = 0; b < LINE_ROWS; b++)
               nbhd[a][b] = line_rows[slot][cx - (LINE_ROWS - 1) + b];
         end
         best = 32'hFFFF_FFFF;
         for (k = 0; k < 4; k++) begin
            sum = 0;
            for (i = 1; i <= 3; i++) begin
               for (j = 1; j <= 3; j++) begin
                  d = int'(nbhd[i][j]) - int'(nbhd[i + SHIFT_ROW[k]][j + SHIFT_COL[k]]);
                  sum += d * d;
               end
            end
            if (sum < best) best = sum;
         end
         if (best > RESP_CAP) best = RESP_CAP;
         // centre sits two rows and two columns behind the newest pixel
         want.center_x  = mcr_pkg::COORD_W'(cx - 2);
         want.center_y  = mcr_pkg::COORD_W'(cy - 2);
         want.response  = mcr_pkg::RESP_W'(best);
         want.is_corner = (best > thresh_cfg);
         expected_q.insert(expected_q.size(), want);
      end
      // the row ends on the width in force, even one shrunk below the column
      if (cx + 1 >= w) begin
         col_pos = 0;
         row_pos = (cy + 1 >= h) ? 0 : cy + 1;
      end else begin
         col_pos = cx + 1;
      end
   endfunction

   // pixels left before the raster wraps to the top of a frame
   function automatic int unsigned frame_remaining();
      int unsigned w, h, in_row, rows_after;
      w = clamp_dim(width_cfg);
      h = clamp_dim(height_cfg);
      in_row     = (col_pos >= w) ? 1 : w - col_pos;
      rows_after = (row_pos + 1 >= h) ? 0 : h - row_pos - 1;
      return in_row + rows_after * w;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // wait per transaction: mostly none, often 0..19, with bursts of back-to-back
   function automatic int unsigned draw_wait(inout int unsigned burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic pattern_type pick_pattern();
      int unsigned r;
      r = $urandom_range(0, 8);
      if (r > PAT_RAMP) return PAT_NOISE;
      return pattern_type'(r);
   endfunction

   // alternating pixels give a checkerboard on odd widths and stripes on even ones
   function automatic mcr_pkg::pixel_type pattern_pixel(input pattern_type kind,
                                                        input int unsigned n,
                                                        input mcr_pkg::pixel_type base);
      case (kind)
         PAT_ALTERNATE: return (n % 2) ? 8'hFF : 8'h00;
         PAT_FLAT:      return base;
         PAT_SPIKES:    return ($urandom_range(0, 11) == 0) ? ~base : base;
         PAT_EXTREMES: begin
            if ($urandom_range(0, 1) == 0)
               return mcr_pkg::pixel_type'($urandom_range(0, 3));
            return mcr_pkg::pixel_type'($urandom_range(252, 255));
         end
         PAT_RAMP:      return base + mcr_pkg::pixel_type'(n * 7);
         default:       return mcr_pkg::pixel_type'($urandom);
      endcase
   endfunction

   function automatic logic [mcr_pkg::THR_W-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 20'd585225;   // top response is never above it
         2:       return 20'd585224;   // top response just above it
         3:       return '1;
         4:       return mcr_pkg::THR_W'($urandom);
         default: return mcr_pkg::THR_W'($urandom_range(0, 150000));
      endcase
   endfunction

   // dimension word with junk above the 9-bit field
   function automatic logic [mcr_pkg::THR_W-1:0] dim_word(input int unsigned dim);
      logic [mcr_pkg::THR_W-1:0] word;
      word = mcr_pkg::THR_W'($urandom);
      word[mcr_pkg::DIM_W-1:0] = mcr_pkg::DIM_W'(dim);
      return word;
   endfunction

   task automatic write_csr(input mcr_pkg::csr_index_type idx,
                            input logic [mcr_pkg::THR_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      case (idx)
         mcr_pkg::CSR_IMAGE_WIDTH:      width_cfg = value[mcr_pkg::DIM_W-1:0];
         mcr_pkg::CSR_IMAGE_HEIGHT:     height_cfg = value[mcr_pkg::DIM_W-1:0];
         mcr_pkg::CSR_CORNER_THRESHOLD: thresh_cfg = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic queue_pixels(input int unsigned count, input pattern_type kind);
      mcr_pkg::pixel_type base;
      int unsigned        n;
      @(negedge clock);
      base = mcr_pkg::pixel_type'($urandom);
      for (n = 0; n < count; n++)
         pixel_q.insert(pixel_q.size(), pattern_pixel(kind, n, base));
      sent_items += count;
   endtask

   // hold the sender until every owed result is back, then let the pipe empty
   task automatic settle();
      do @(negedge clock);
      while (pixel_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // pixel driver: one transaction per pop, waits drawn per item
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            predict_pixel(req_pixel);
         // a held pixel stays put while stalled
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pixel_q.size() != 0) begin
               req_valid <= 1'b1;
               req_pixel <= pixel_q.pop_front();
               gap_left = draw_wait(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor: compare against the oldest prediction, stall at random
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      mcr_pkg::out_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, got x=%0d y=%0d resp=%0d corner=%0b",
                        $time, rsp_center_x, rsp_center_y, rsp_response, rsp_is_corner);
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("center_x", want.center_x, rsp_center_x);
               check_field("center_y", want.center_y, rsp_center_y);
               check_field("response", want.response, rsp_response);
               check_field("is_corner", want.is_corner, rsp_is_corner);
            end
            stall_left = draw_wait(stall_burst);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // cycles without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      do @(posedge clock);
      while (idle_cycles < IDLE_LIMIT);
      $display("%0t: timeout, %0d results still owed", $time, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int unsigned count;
      int unsigned w_eff;
      bit          wide_done;
      wide_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed frame: odd width for a full-swing checkerboard, so every centre
      // scores the top response; height below the floor saturates to 8
      write_csr(mcr_pkg::CSR_IMAGE_WIDTH, 20'd9);
      write_csr(mcr_pkg::CSR_IMAGE_HEIGHT, 20'd0);
      write_csr(mcr_pkg::CSR_CORNER_THRESHOLD, 20'd585224);
      queue_pixels(frame_remaining(), PAT_ALTERNATE);

      while (sent_items < ITEM_BUDGET) begin
         settle();

         // full-width rows at a frame start: both dimensions above the ceiling, a
         // row and a half so the column count wraps at the top width, then narrow
         // mid-frame
         if (!wide_done && sent_items >= WIDE_AFTER) begin
            queue_pixels(frame_remaining(), pick_pattern());
            settle();
            write_csr(mcr_pkg::CSR_IMAGE_WIDTH, dim_word(9'h1FF));
            write_csr(mcr_pkg::CSR_IMAGE_HEIGHT, dim_word(300));
            queue_pixels(WIDE_PIXELS, pick_pattern());
            settle();
            write_csr(mcr_pkg::CSR_IMAGE_WIDTH, dim_word(10));
            write_csr(mcr_pkg::CSR_IMAGE_HEIGHT, dim_word(40));
            wide_done = 1'b1;
         end

         write_csr(mcr_pkg::CSR_CORNER_THRESHOLD, pick_threshold());
         w_eff = clamp_dim(width_cfg);
         if (col_pos == 0 && row_pos == 0) begin
            // frame boundary: any size, now and then below the floor
            write_csr(mcr_pkg::CSR_IMAGE_WIDTH,
                      dim_word(($urandom_range(0, 5) == 0) ?
                               $urandom_range(0, 7) : $urandom_range(8, 20)));
            write_csr(mcr_pkg::CSR_IMAGE_HEIGHT,
                      dim_word(($urandom_range(0, 5) == 0) ?
                               $urandom_range(0, 7) : $urandom_range(8, 14)));
         end else begin
            // mid-frame: height may drop under the current row, width only shrinks
            // so that no window reaches columns this frame never wrote
            case ($urandom_range(0, 2))
               0:       write_csr(mcr_pkg::CSR_IMAGE_HEIGHT, dim_word($urandom_range(0, 16)));
               1:       write_csr(mcr_pkg::CSR_IMAGE_WIDTH, dim_word($urandom_range(0, w_eff)));
               default: ;
            endcase
         end

         case ($urandom_range(0, 2))
            0:       count = frame_remaining();
            1:       count = frame_remaining() + clamp_dim(width_cfg) * clamp_dim(height_cfg);
            default: count = $urandom_range(1, 3 * clamp_dim(width_cfg));
         endcase
         // keep the whole run near the item budget
         if (sent_items + count > ITEM_BUDGET)
            count = (sent_items < ITEM_BUDGET) ? ITEM_BUDGET - sent_items : 0;
         queue_pixels(count, pick_pattern());
      end

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
